// File: rtl/depth_sort_by_camera_distance_defines.svh
// Assertion macros for the depth sorter checker.
`ifndef DEPTH_SORT_BY_CAMERA_DISTANCE_DEFINES_SVH
`define DEPTH_SORT_BY_CAMERA_DISTANCE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DSORT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsort assertion failed");

// Next-cycle implication, off during reset.
`define DSORT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsort assertion failed");

// Next-cycle implication, checked during reset too.
`define DSORT_ASSERT_NXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dsort assertion failed");

`endif

// File: rtl/dsort_pkg.sv
// Types and constants shared by the depth sorter modules.
package dsort_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int KEY_W       = 36;
  localparam int COORD_W     = 16;
  localparam int SQ_W        = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_last;
    logic                      overflowed;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    point_t           pt;
  } entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } camera_t;

endpackage

// File: rtl/dsort_front.sv
// Front end: squared camera distance of each point, two register stages.
module dsort_front import dsort_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  camera_t camera,
  input  logic    point_valid,
  output logic    point_stall,
  input  point_t  point,
  output logic    push_valid,
  input  logic    push_ready,
  output entry_t  push_entry
);

  logic              s1_valid;
  point_t            s1_pt;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_z;
  logic              s2_valid;
  entry_t            s2_entry;
  logic              s1_free;
  logic              s2_free;
  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [COORD_W:0]     dz;
  logic signed [2*COORD_W+1:0] px;
  logic signed [2*COORD_W+1:0] py;
  logic signed [2*COORD_W+1:0] pz;

  assign dx = {point.point_x[COORD_W-1], point.point_x} - {camera.x[COORD_W-1], camera.x};
  assign dy = {point.point_y[COORD_W-1], point.point_y} - {camera.y[COORD_W-1], camera.y};
  assign dz = {point.point_z[COORD_W-1], point.point_z} - {camera.z[COORD_W-1], camera.z};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign s2_free     = !s2_valid || push_ready;
  assign s1_free     = !s1_valid || s2_free;
  assign point_stall = !s1_free;
  assign push_valid  = s2_valid;
  assign push_entry  = s2_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= point_valid;
      if (s2_free) s2_valid <= s1_valid;
    end
    if (s1_free) begin
      s1_pt <= point;
      sq_x  <= px[SQ_W-1:0];
      sq_y  <= py[SQ_W-1:0];
      sq_z  <= pz[SQ_W-1:0];
    end
    if (s2_free) begin
      s2_entry.pt  <= s1_pt;
      s2_entry.key <= KEY_W'(sq_x) + KEY_W'(sq_y) + KEY_W'(sq_z);
    end
  end

endmodule

// File: rtl/dsort_queue.sv
// Short FIFO between the distance front end and the sorter.
module dsort_queue import dsort_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_take,
  output entry_t pop_entry
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

// File: rtl/dsort_back.sv
// Back end: insertion sorter row of cells and the drain to the result register.
module dsort_back import dsort_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pop_valid,
  output logic    pop_take,
  input  entry_t  pop_entry,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [1:0] {
    FILL  = 2'b01,
    DRAIN = 2'b10
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic                        dropped;
  logic [KEY_W-1:0]            key_cell [MAX_POINTS];
  logic [3*COORD_W-1:0]        pt_cell  [MAX_POINTS];
  logic [MAX_POINTS-1:0]       ins;
  logic                        full;
  logic                        out_free;
  logic [3*COORD_W-1:0]        new_pt;

  assign full     = count == CNT_W'(MAX_POINTS);
  assign out_free = !result_valid || !result_stall;
  assign pop_take = state == FILL;
  assign new_pt   = {pop_entry.pt.point_z, pop_entry.pt.point_y, pop_entry.pt.point_x};

  // A cell takes part in the insert when it is empty or holds a smaller key.
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      ins[i] = (CNT_W'(i) >= count) || (pop_entry.key > key_cell[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FILL;
      count        <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == DRAIN && out_free) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      unique case (state)
        FILL: begin
          if (pop_valid) begin
            if (full) dropped <= 1'b1;
            else count <= count + 1'b1;
            if (pop_entry.pt.last_point) state <= DRAIN;
          end
        end
        DRAIN: begin
          if (out_free) begin
            count <= count - 1'b1;
            if (count == CNT_W'(1)) begin
              state   <= FILL;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= FILL;
      endcase
    end

    if (state == FILL && pop_valid && !full) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (ins[i]) begin
          if (i == 0 || !ins[(i == 0) ? 0 : i-1]) begin
            key_cell[i] <= pop_entry.key;
            pt_cell[i]  <= new_pt;
          end else begin
            key_cell[i] <= key_cell[(i == 0) ? 0 : i-1];
            pt_cell[i]  <= pt_cell[(i == 0) ? 0 : i-1];
          end
        end
      end
    end

    if (state == DRAIN && out_free) begin
      result.out_x      <= pt_cell[0][COORD_W-1:0];
      result.out_y      <= pt_cell[0][2*COORD_W-1:COORD_W];
      result.out_z      <= pt_cell[0][3*COORD_W-1:2*COORD_W];
      result.out_last   <= count == CNT_W'(1);
      result.overflowed <= dropped;
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        key_cell[i] <= key_cell[i+1];
        pt_cell[i]  <= pt_cell[i+1];
      end
    end
  end

endmodule

// File: rtl/depth_sort_by_camera_distance.sv
// Top level of the back-to-front depth sorter.
//
// Points enter at up to one per cycle. Each gets its squared distance to the
// camera in a two-stage front end (three 17x17 squares, then a 36-bit sum)
// and goes through a four-entry queue into a row of MAX_POINTS sorter cells
// that inserts one point per cycle, keeping points farthest first and equal
// distances in arrival order. After the point marked last is taken the
// row drains one result per cycle unless result_stall holds it, during
// which the sorter takes no point; the front end keeps accepting until the
// queue and its stages are full (six points). Points beyond MAX_POINTS are
// dropped and every result of that set carries overflowed. Camera registers
// take effect on points accepted after the write.
module depth_sort_by_camera_distance import dsort_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  point_t               point,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  camera_t camera;
  logic    push_valid;
  logic    push_ready;
  entry_t  push_entry;
  logic    pop_valid;
  logic    pop_take;
  entry_t  pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X: camera.x <= cfg_data;
        REG_CAMERA_Y: camera.y <= cfg_data;
        REG_CAMERA_Z: camera.z <= cfg_data;
        default:      camera   <= camera;
      endcase
    end
  end

  dsort_front u_front (
    .clk         (clk),
    .rst         (rst),
    .camera      (camera),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  dsort_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_entry  (pop_entry)
  );

  dsort_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_take     (pop_take),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/dsort_checker.sv
// Port-level checks for the depth sorter, bound to the top level.
`include "depth_sort_by_camera_distance_defines.svh"

module dsort_checker import dsort_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `DSORT_ASSERT_NXT_ALWAYS(a_idle_after_reset, rst, !result_valid)
  `DSORT_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
  `DSORT_ASSERT_IMP(a_run_flag_steady, result_valid && !result_stall && !result.out_last ##1 result_valid, result.overflowed == $past(result.overflowed))

endmodule

bind depth_sort_by_camera_distance dsort_checker u_dsort_checker (.*);
